/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent check forms, clocked on clock and disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every edge
`define OBP_CHECK(name, expr) \
   name: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("obp check failed");

// consequent holds in the same cycle as the antecedent
`define OBP_CHECK_IMPL(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("obp implication failed");

// consequent holds in the cycle after the antecedent
`define OBP_CHECK_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("obp next-cycle check failed");

`endif

/* hw/rtl/obp_pkg.sv */
// ----------------------------------------------------------------------------
// obp_pkg
// types and constants of the online bin packing block
// ----------------------------------------------------------------------------
`default_nettype none

package obp_pkg;

   localparam int MAX_BINS_DEFAULT = 64;

   localparam int SIZE_W     = 17;
   localparam int FILL_W     = 17;
   localparam int SUM_W      = FILL_W + 1;
   localparam int IDX_OUT_W  = 6;
   localparam int MODE_W     = 2;
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 17;

   // fit mode codes
   localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
   localparam logic [MODE_W-1:0] MODE_NEXT  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_BEST  = 2'd2;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_FIT_MODE     = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_BIN_CAPACITY = 1'd1;

   localparam logic [FILL_W-1:0] CAPACITY_RESET = 17'd65536;

   typedef struct packed {
      logic [SIZE_W-1:0] item_size;
      logic              first_item;
   } req_type;

   typedef struct packed {
      logic [IDX_OUT_W-1:0] bin_index;
      logic                 opened_new;
      logic [FILL_W-1:0]    fill_after;
      logic                 overflow;
   } rsp_type;

   // status of the shared fit unit
   typedef struct packed {
      logic              fits;
      logic              better;
      logic [FILL_W-1:0] fill;
      logic [FILL_W-1:0] left;
   } fit_result_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_CHECK,
      ST_WRITE,
      ST_FINISH
   } state_type;

endpackage

`default_nettype wire

/* hw/rtl/online_bin_packing.sv */
// each scanned bin is read, then checked (first fit stops at the first bin that fits,
// best fit reads every open bin, next fit reads one), then the pick is written and
// finish registers the result; with no open bin idle goes to write, an oversized item
// to finish, and with no bin left check goes to finish; req_stall holds the next item
// until idle, so one item is in flight; the single ram read port sets the scan rate
// reset (synchronous, active high) empties all bins and restores the registers
// ----------------------------------------------------------------------------
// online_bin_packing
// online bin packing by first, next or best fit over a fill ram
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module online_bin_packing #(
   parameter int MAX_BINS = obp_pkg::MAX_BINS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   // item channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  obp_pkg::req_type               req_data,
   // result channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output obp_pkg::rsp_type               rsp_data,
   // register writes
   input  logic                           csr_wr_en,
   input  logic [obp_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [obp_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import obp_pkg::*;

   localparam int BIN_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
   localparam int CNT_W = $clog2(MAX_BINS + 1);

   // sequencer and configuration
   state_type         state_ff, state_in;
   logic [MODE_W-1:0] fit_mode_ff, fit_mode_in;
   logic [FILL_W-1:0] bin_capacity_ff, bin_capacity_in;
   logic [CNT_W-1:0]  bin_count_ff, bin_count_in;

   // working registers of the item in flight
   logic [SIZE_W-1:0] size_ff, size_in;
   logic [BIN_W-1:0]  scan_idx_ff, scan_idx_in;
   logic [BIN_W-1:0]  last_idx_ff, last_idx_in;
   logic              pick_valid_ff, pick_valid_in;
   logic [BIN_W-1:0]  pick_ff, pick_in;
   logic [FILL_W-1:0] least_ff, least_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              opened_ff, opened_in;
   logic              overflow_ff, overflow_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   // fill ram and fit unit hookup
   logic              ram_wr_en;
   logic              ram_rd_en;
   logic [FILL_W-1:0] ram_rd_data;
   logic [FILL_W-1:0] fu_fill;
   logic [SIZE_W-1:0] fu_size;
   fit_result_type    fu;

   // decision terms
   logic              req_acc;
   logic              rsp_free;
   logic [CNT_W-1:0]  count_eff;
   logic [CNT_W-1:0]  count_m1;
   logic              take_now;
   logic              best_upd;
   logic              scan_last;
   logic              any_pick;
   logic              can_open;
   logic [IDX_OUT_W+BIN_W-1:0] pick_wide;

   assign req_acc   = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // first_item empties the bin set before placement
   assign count_eff = req_data.first_item ? '0 : bin_count_ff;
   assign count_m1  = count_eff - 1'b1;

   // while idle the unit sees an empty bin, so fits flags an oversized item
   assign fu_fill = (state_ff == ST_CHECK) ? ram_rd_data : '0;
   assign fu_size = (state_ff == ST_IDLE) ? req_data.item_size : size_ff;

   assign take_now  = fu.fits && (fit_mode_ff != MODE_BEST);
   assign best_upd  = fu.fits && fu.better && (fit_mode_ff == MODE_BEST);
   assign scan_last = (scan_idx_ff == last_idx_ff);
   assign any_pick  = pick_valid_ff || best_upd;
   assign can_open  = (bin_count_ff < CNT_W'(MAX_BINS));
   assign pick_wide = {{IDX_OUT_W{1'b0}}, pick_ff};

   obp_fit_unit u_fit (
      .fill       (fu_fill),
      .size       (fu_size),
      .capacity   (bin_capacity_ff),
      .least      (least_ff),
      .pick_valid (pick_valid_ff),
      .result     (fu)
   );

   obp_ram #(
      .WIDTH (FILL_W),
      .DEPTH (MAX_BINS),
      .AW    (BIN_W)
   ) u_fill_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (pick_ff),
      .wr_data (fill_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (scan_idx_ff),
      .rd_data (ram_rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (!fu.fits) begin
                  state_in = ST_FINISH;
               end else if (count_eff == '0) begin
                  state_in = ST_WRITE;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (take_now) begin
               state_in = ST_WRITE;
            end else if (!scan_last) begin
               state_in = ST_READ;
            end else if (any_pick || can_open) begin
               state_in = ST_WRITE;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_WRITE: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      ram_rd_en = (state_ff == ST_READ);
      ram_wr_en = (state_ff == ST_WRITE);
   end

   // configuration writes
   always_comb begin
      fit_mode_in     = fit_mode_ff;
      bin_capacity_in = bin_capacity_ff;
      if (csr_wr_en) begin
         unique case (csr_addr)
            CSR_FIT_MODE:     fit_mode_in     = csr_wdata[MODE_W-1:0];
            CSR_BIN_CAPACITY: bin_capacity_in = csr_wdata[FILL_W-1:0];
         endcase
      end
   end

   // working registers
   always_comb begin
      bin_count_in  = bin_count_ff;
      size_in       = size_ff;
      scan_idx_in   = scan_idx_ff;
      last_idx_in   = last_idx_ff;
      pick_valid_in = pick_valid_ff;
      pick_in       = pick_ff;
      least_in      = least_ff;
      fill_in       = fill_ff;
      opened_in     = opened_ff;
      overflow_in   = overflow_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_in        = rsp_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               size_in       = req_data.item_size;
               bin_count_in  = count_eff;
               pick_valid_in = 1'b0;
               overflow_in   = !fu.fits;
               opened_in     = 1'b0;
               last_idx_in   = count_m1[BIN_W-1:0];
               // next fit tries only the last opened bin
               scan_idx_in   = (fit_mode_ff == MODE_NEXT) ? count_m1[BIN_W-1:0] : '0;
               if (fu.fits && (count_eff == '0)) begin
                  pick_in   = '0;
                  opened_in = 1'b1;
                  fill_in   = fu.fill;
               end
            end
         end
         ST_CHECK: begin
            scan_idx_in = scan_idx_ff + 1'b1;
            if (take_now) begin
               pick_in = scan_idx_ff;
               fill_in = fu.fill;
            end else begin
               if (best_upd) begin
                  pick_valid_in = 1'b1;
                  pick_in       = scan_idx_ff;
                  least_in      = fu.left;
                  fill_in       = fu.fill;
               end
               if (scan_last && !any_pick) begin
                  if (can_open) begin
                     pick_in   = bin_count_ff[BIN_W-1:0];
                     opened_in = 1'b1;
                     fill_in   = size_ff;
                  end else begin
                     overflow_in = 1'b1;
                  end
               end
            end
         end
         ST_WRITE: begin
            if (opened_ff) begin
               bin_count_in = bin_count_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               if (overflow_ff) begin
                  rsp_in            = '0;
                  rsp_in.overflow   = 1'b1;
               end else begin
                  rsp_in.bin_index  = pick_wide[IDX_OUT_W-1:0];
                  rsp_in.opened_new = opened_ff;
                  rsp_in.fill_after = fill_ff;
                  rsp_in.overflow   = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         fit_mode_ff     <= MODE_FIRST;
         bin_capacity_ff <= CAPACITY_RESET;
         bin_count_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         fit_mode_ff     <= fit_mode_in;
         bin_capacity_ff <= bin_capacity_in;
         bin_count_ff    <= bin_count_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      size_ff       <= size_in;
      scan_idx_ff   <= scan_idx_in;
      last_idx_ff   <= last_idx_in;
      pick_valid_ff <= pick_valid_in;
      pick_ff       <= pick_in;
      least_ff      <= least_in;
      fill_ff       <= fill_in;
      opened_ff     <= opened_in;
      overflow_ff   <= overflow_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // never more bins than the ram holds
   `OBP_CHECK(a_count_bound, bin_count_ff <= CNT_W'(MAX_BINS))
   // an overflow result carries no placement
   `OBP_CHECK_IMPL(a_overflow_clean, rsp_valid_ff && rsp_ff.overflow,
                   rsp_ff.fill_after == '0 && !rsp_ff.opened_new && rsp_ff.bin_index == '0)
   // the scan stays inside the open bins
   `OBP_CHECK_IMPL(a_scan_range, state_ff == ST_CHECK, scan_idx_ff <= last_idx_ff)
   // opening a bin bumps the count by one
   `OBP_CHECK_NEXT(a_open_count, state_ff == ST_WRITE && opened_ff,
                   bin_count_ff == $past(bin_count_ff) + 1'b1)

endmodule

`default_nettype wire

/* hw/rtl/obp_ram.sv */
// ----------------------------------------------------------------------------
// obp_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module obp_ram #(
   parameter int WIDTH = obp_pkg::FILL_W,
   parameter int DEPTH = obp_pkg::MAX_BINS_DEFAULT,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hw/rtl/obp_fit_unit.sv */
// ----------------------------------------------------------------------------
// obp_fit_unit
// shared add and compare: fill plus size against capacity, space left
// ----------------------------------------------------------------------------
`default_nettype none

module obp_fit_unit (
   input  logic [obp_pkg::FILL_W-1:0] fill,
   input  logic [obp_pkg::SIZE_W-1:0] size,
   input  logic [obp_pkg::FILL_W-1:0] capacity,
   input  logic [obp_pkg::FILL_W-1:0] least,
   input  logic                       pick_valid,
   output obp_pkg::fit_result_type    result
);
   import obp_pkg::*;

   logic [SUM_W-1:0]  sum;
   logic [FILL_W-1:0] left;

   always_comb begin
      sum  = {1'b0, fill} + {1'b0, size};
      left = capacity - sum[FILL_W-1:0];
      result.fits   = (sum <= {1'b0, capacity});
      result.fill   = sum[FILL_W-1:0];
      result.left   = left;
      // strict compare keeps ties on the lower bin
      result.better = !pick_valid || (left < least);
   end

endmodule

`default_nettype wire
